[rtl/core/gtq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the glove touch qualifier.
// No dependencies; imported by every module of the block.
package gtq_pkg;

  localparam int SLOT_W  = 4;
  localparam int POS_W   = 12;
  localparam int PRES_W  = 8;
  localparam int KIND_W  = 2;
  localparam int TIME_W  = 32;
  localparam int WIN_W   = 16;
  localparam int THR_W   = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FINGER_WINDOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_RESET    = 16'd100;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd30;

  localparam logic [KIND_W-1:0] KIND_FINGER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_FINGER = 2'd1,
    MODE_ZERO   = 2'd2,
    MODE_GLOVE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_PRESS   = 2'd1,
    ST_RELEASE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_RELEASE = 3'd0,
    OP_IGNORE  = 3'd1,
    OP_PASS    = 3'd2,
    OP_FINGER  = 3'd3,
    OP_FILTER  = 3'd4
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [PRES_W-1:0]  pressure;
    logic [TIME_W-1:0]  now;
  } gtq_item_t;

endpackage

[rtl/core/gtq_front.sv]
`timescale 1ns / 1ps
// Front end: takes input transactions and classifies them into queue items.
// Depends on gtq_pkg.
module gtq_front import gtq_pkg::*; #(
  parameter int FILTERED_SLOTS = 4,
  parameter int MAX_SLOTS      = 10
) (
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [POS_W-1:0]  in_x_pos,
  input  logic [POS_W-1:0]  in_y_pos,
  input  logic [PRES_W-1:0] in_pressure,
  input  logic [KIND_W-1:0] in_contact_kind,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              q_full,
  output logic              push,
  output gtq_item_t         push_item
);

  logic ignored;
  logic filtered;

  assign in_ready = rst_n && !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    ignored  = ({1'b0, in_slot} >= (SLOT_W+1)'(MAX_SLOTS)) ||
               ((in_x_pos == '0) && (in_y_pos == '0));
    filtered = {1'b0, in_slot} < (SLOT_W+1)'(FILTERED_SLOTS);

    push_item.slot     = in_slot;
    push_item.x        = in_x_pos;
    push_item.y        = in_y_pos;
    push_item.pressure = in_pressure;
    push_item.now      = in_now_ms;

    if (in_action) begin
      push_item.op = OP_RELEASE;
    end else if (ignored) begin
      push_item.op = OP_IGNORE;
    end else if (!filtered || (in_contact_kind == KIND_UNKNOWN)) begin
      push_item.op = OP_PASS;
    end else if (in_contact_kind == KIND_FINGER) begin
      push_item.op = OP_FINGER;
    end else begin
      push_item.op = OP_FILTER;
    end
  end

endmodule

[rtl/core/gtq_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue between the front end and the back end.
// Depends on gtq_pkg.
module gtq_queue import gtq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  gtq_item_t push_item,
  input  logic      pop,
  output logic      q_valid,
  output logic      q_full,
  output gtq_item_t q_item
);

  gtq_item_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     count_r;

  assign q_valid = count_r != '0;
  assign q_full  = count_r == (Q_AW+1)'(Q_DEPTH);
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/core/gtq_back.sv]
`timescale 1ns / 1ps
// Back end: mode and per-slot anchor state, qualification and output register.
// Depends on gtq_pkg; also holds the configuration registers.
module gtq_back import gtq_pkg::*; #(
  parameter int FILTERED_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  gtq_item_t             q_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [POS_W-1:0]      out_x,
  output logic [POS_W-1:0]      out_y,
  output logic [PRES_W-1:0]     out_pressure,
  output logic [1:0]            out_report_status
);

  localparam int FW = (FILTERED_SLOTS > 1) ? $clog2(FILTERED_SLOTS) : 1;

  logic [WIN_W-1:0]    window_r;
  logic [THR_W-1:0]    threshold_r;
  logic [2*THR_W-1:0]  thr_sq_r;

  mode_t               mode_r, mode_nxt;
  logic                anchor_valid_r [FILTERED_SLOTS];
  logic [POS_W-1:0]    anchor_x_r     [FILTERED_SLOTS];
  logic [POS_W-1:0]    anchor_y_r     [FILTERED_SLOTS];
  logic [TIME_W-1:0]   finger_time_r  [FILTERED_SLOTS];

  logic                out_valid_r;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [POS_W-1:0]    out_x_r, out_x_nxt;
  logic [POS_W-1:0]    out_y_r, out_y_nxt;
  logic [PRES_W-1:0]   out_pressure_r, out_pressure_nxt;
  status_t             out_status_r, out_status_nxt;

  logic [FW-1:0]       idx;
  logic [POS_W-1:0]    dx, dy;
  logic [2*POS_W-1:0]  dx_sq, dy_sq;
  logic [2*POS_W:0]    dist_sq;
  logic [TIME_W-1:0]   gap;
  logic                in_window;
  logic                far;
  logic                report;
  logic                anchor_wr;
  logic                ftime_wr;
  logic                release_op;

  assign cfg_ready = 1'b1;
  assign pop       = q_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      threshold_r <= THRESHOLD_RESET;
      thr_sq_r    <= THRESHOLD_RESET * THRESHOLD_RESET;
    end else begin
      thr_sq_r <= threshold_r * threshold_r;
      if (cfg_valid) begin
        case (cfg_index)
          REG_FINGER_WINDOW:  window_r    <= cfg_data[WIN_W-1:0];
          REG_MOVE_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
          default:            window_r    <= window_r;
        endcase
      end
    end
  end

  always_comb begin
    idx       = q_item.slot[FW-1:0];
    dx        = (anchor_x_r[idx] > q_item.x) ? (anchor_x_r[idx] - q_item.x)
                                             : (q_item.x - anchor_x_r[idx]);
    dy        = (anchor_y_r[idx] > q_item.y) ? (anchor_y_r[idx] - q_item.y)
                                             : (q_item.y - anchor_y_r[idx]);
    dx_sq     = dx * dx;
    dy_sq     = dy * dy;
    dist_sq   = {1'b0, dx_sq} + {1'b0, dy_sq};
    far       = dist_sq >= {1'b0, thr_sq_r};
    gap       = q_item.now - finger_time_r[idx];
    in_window = (gap != '0) && (gap <= {{(TIME_W-WIN_W){1'b0}}, window_r});

    mode_nxt   = mode_r;
    report     = 1'b0;
    anchor_wr  = 1'b0;
    ftime_wr   = 1'b0;
    release_op = 1'b0;

    case (q_item.op)
      OP_RELEASE: release_op = 1'b1;
      OP_IGNORE:  report = 1'b0;
      OP_PASS:    report = 1'b1;
      OP_FINGER: begin
        mode_nxt = MODE_FINGER;
        report   = 1'b1;
      end
      OP_FILTER: begin
        case (mode_r)
          MODE_INIT: begin
            mode_nxt = MODE_GLOVE;
            report   = 1'b1;
          end
          MODE_FINGER: begin
            if (in_window) begin
              ftime_wr = 1'b1;
            end else begin
              mode_nxt = MODE_ZERO;
            end
          end
          MODE_ZERO: begin
            if (!anchor_valid_r[idx]) begin
              anchor_wr = 1'b1;
            end else if (far) begin
              mode_nxt = MODE_GLOVE;
            end
          end
          default: report = 1'b1;
        endcase
      end
      default: report = 1'b0;
    endcase

    out_slot_nxt     = release_op ? '0 : q_item.slot;
    out_x_nxt        = report ? q_item.x : '0;
    out_y_nxt        = report ? q_item.y : '0;
    out_pressure_nxt = report ? q_item.pressure : '0;
    if (release_op) begin
      out_status_nxt = ST_RELEASE;
    end else if (report) begin
      out_status_nxt = ST_PRESS;
    end else begin
      out_status_nxt = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INIT;
      for (int i = 0; i < FILTERED_SLOTS; i++) begin
        anchor_valid_r[i] <= 1'b0;
        anchor_x_r[i]     <= '0;
        anchor_y_r[i]     <= '0;
        finger_time_r[i]  <= '0;
      end
    end else if (pop) begin
      mode_r <= mode_nxt;
      if (release_op) begin
        for (int i = 0; i < FILTERED_SLOTS; i++) begin
          anchor_valid_r[i] <= 1'b0;
          if (mode_r == MODE_FINGER) begin
            finger_time_r[i] <= q_item.now;
          end
        end
      end
      if (anchor_wr) begin
        anchor_valid_r[idx] <= 1'b1;
        anchor_x_r[idx]     <= q_item.x;
        anchor_y_r[idx]     <= q_item.y;
      end
      if (ftime_wr) begin
        finger_time_r[idx] <= q_item.now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_slot_r     <= out_slot_nxt;
      out_x_r        <= out_x_nxt;
      out_y_r        <= out_y_nxt;
      out_pressure_r <= out_pressure_nxt;
      out_status_r   <= out_status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot          = out_slot_r;
  assign out_x             = out_x_r;
  assign out_y             = out_y_r;
  assign out_pressure      = out_pressure_r;
  assign out_report_status = out_status_r;

endmodule

[rtl/core/glove_touch_qualifier.sv]
`timescale 1ns / 1ps
// Glove touch qualifier: suppresses glove and stylus contacts after finger use
// until they move away from an anchor point; one result per slot report.
// Input channel in_*: one slot report or a release frame (in_action high) per
// transaction. Output channel out_*: exactly one result per input transaction,
// in order, with out_report_status 0 none, 1 press, 2 release.
// Configuration channel cfg_*: index 0 finger window in ms, index 1 movement
// threshold; always ready, write only while the block is idle.
// A transaction is registered in the queue, then in the output register; throughput is one
// transaction per cycle while the receiver accepts, set by the combinational qualify step in the back end.
// A two-entry queue sits between front and back end and the result sits in an
// output register, so a stalled receiver stalls the back end first and the
// input side only once the queue is full; nothing is dropped.
// Reset (rst_n low, synchronous) empties the queue and the output register,
// sets the mode to init, clears all anchors and finger times and restores the
// configuration defaults (100 ms, 30 units). No clearing pass is needed.
// Depends on gtq_pkg, gtq_front, gtq_queue and gtq_back.
module glove_touch_qualifier import gtq_pkg::*; #(
  parameter int FILTERED_SLOTS = 4,
  parameter int MAX_SLOTS      = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [POS_W-1:0]      in_x_pos,
  input  logic [POS_W-1:0]      in_y_pos,
  input  logic [PRES_W-1:0]     in_pressure,
  input  logic [KIND_W-1:0]     in_contact_kind,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [POS_W-1:0]      out_x,
  output logic [POS_W-1:0]      out_y,
  output logic [PRES_W-1:0]     out_pressure,
  output logic [1:0]            out_report_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      push;
  logic      pop;
  logic      q_valid;
  logic      q_full;
  gtq_item_t push_item;
  gtq_item_t q_item;

  gtq_front #(
    .FILTERED_SLOTS (FILTERED_SLOTS),
    .MAX_SLOTS      (MAX_SLOTS)
  ) u_front (
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_slot         (in_slot),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_pressure     (in_pressure),
    .in_contact_kind (in_contact_kind),
    .in_now_ms       (in_now_ms),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  gtq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  gtq_back #(
    .FILTERED_SLOTS (FILTERED_SLOTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slot          (out_slot),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_pressure      (out_pressure),
    .out_report_status (out_report_status)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for glove_touch_qualifier: directed and random slot reports,
// with a scoreboard class that predicts each result and checks the output channel.
// Depends on gtq_pkg and the glove_touch_qualifier RTL.
module testbench import gtq_pkg::*;;

  localparam int FILTERED_SLOTS = 4;
  localparam int MAX_SLOTS      = 10;
  localparam int HALF_PERIOD    = 10;
  localparam int PHASE_ITEMS    = 188;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct {
    logic               action;
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [PRES_W-1:0]  pressure;
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  now;
  } touch_report_t;

  typedef struct {
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [PRES_W-1:0]  pressure;
    logic [1:0]         status;
  } touch_result_t;

  class touch_scoreboard;
    mode_t              mode;
    bit                 anchor_ok[FILTERED_SLOTS];
    logic [POS_W-1:0]   anchor_x[FILTERED_SLOTS];
    logic [POS_W-1:0]   anchor_y[FILTERED_SLOTS];
    logic [TIME_W-1:0]  finger_stamp[FILTERED_SLOTS];
    logic [WIN_W-1:0]   window;
    logic [THR_W-1:0]   threshold;
    touch_result_t      awaited[$];
    int unsigned        mismatches;

    function new();
      mode = MODE_INIT;
      foreach (anchor_ok[i]) begin
        anchor_ok[i] = 1'b0;
        anchor_x[i] = '0;
        anchor_y[i] = '0;
        finger_stamp[i] = '0;
      end
      window = WINDOW_RESET;
      threshold = THRESHOLD_RESET;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_FINGER_WINDOW) begin
        window = data[WIN_W-1:0];
      end else begin
        threshold = data[THR_W-1:0];
      end
    endfunction

    function touch_result_t resolve_contact(touch_report_t r);
      touch_result_t     res;
      int                idx;
      logic [TIME_W-1:0] gap;
      int unsigned       dx;
      int unsigned       dy;
      int unsigned       reach;
      int unsigned       thr;
      bit                show;
      res.slot = '0;
      res.x = '0;
      res.y = '0;
      res.pressure = '0;
      res.status = ST_NONE;
      if (r.action) begin
        foreach (anchor_ok[i]) begin
          anchor_ok[i] = 1'b0;
          if (mode == MODE_FINGER) finger_stamp[i] = r.now;
        end
        res.status = ST_RELEASE;
        return res;
      end
      res.slot = r.slot;
      if (r.slot >= MAX_SLOTS || (r.x == 0 && r.y == 0)) return res;
      show = 1'b1;
      if (r.slot < FILTERED_SLOTS) begin
        idx = int'(r.slot);
        if (r.kind == KIND_FINGER) begin
          mode = MODE_FINGER;
        end else if (r.kind != KIND_UNKNOWN) begin
          case (mode)
            MODE_INIT: begin
              mode = MODE_GLOVE;
            end
            MODE_FINGER: begin
              gap = r.now - finger_stamp[idx];
              if (gap != 0 && gap <= {16'd0, window}) finger_stamp[idx] = r.now;
              else mode = MODE_ZERO;
              show = 1'b0;
            end
            MODE_ZERO: begin
              if (!anchor_ok[idx]) begin
                anchor_ok[idx] = 1'b1;
                anchor_x[idx] = r.x;
                anchor_y[idx] = r.y;
              end else begin
                dx = (r.x > anchor_x[idx]) ? r.x - anchor_x[idx] : anchor_x[idx] - r.x;
                dy = (r.y > anchor_y[idx]) ? r.y - anchor_y[idx] : anchor_y[idx] - r.y;
                reach = dx * dx + dy * dy;
                thr = threshold;
                if (reach >= thr * thr) mode = MODE_GLOVE;
              end
              show = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      if (show) begin
        res.x = r.x;
        res.y = r.y;
        res.pressure = r.pressure;
        res.status = ST_PRESS;
      end
      return res;
    endfunction

    function void note_report(touch_report_t r);
      awaited.push_back(resolve_contact(r));
    endfunction

    function void check_result(touch_result_t got);
      touch_result_t want;
      if (awaited.size() == 0) begin
        $error("result for slot %0d arrived with no transaction pending", got.slot);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.slot !== want.slot) begin
        $error("out_slot: expected %0d, actual %0d", want.slot, got.slot);
        mismatches++;
      end
      if (got.x !== want.x) begin
        $error("out_x: expected %0d, actual %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("out_y: expected %0d, actual %0d", want.y, got.y);
        mismatches++;
      end
      if (got.pressure !== want.pressure) begin
        $error("out_pressure: expected %0d, actual %0d", want.pressure, got.pressure);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("out_report_status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_action = 1'b0;
  logic [SLOT_W-1:0]     in_slot = '0;
  logic [POS_W-1:0]      in_x_pos = '0;
  logic [POS_W-1:0]      in_y_pos = '0;
  logic [PRES_W-1:0]     in_pressure = '0;
  logic [KIND_W-1:0]     in_contact_kind = '0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_W-1:0]     out_slot;
  logic [POS_W-1:0]      out_x;
  logic [POS_W-1:0]      out_y;
  logic [PRES_W-1:0]     out_pressure;
  logic [1:0]            out_report_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  touch_scoreboard   sb = new();
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       phase_items = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       cur_window = WINDOW_RESET;
  int unsigned       cur_threshold = THRESHOLD_RESET;
  logic [TIME_W-1:0] clock_ms = 32'd5000;
  bit                hold_request = 1'b0;

  glove_touch_qualifier #(
    .FILTERED_SLOTS(FILTERED_SLOTS),
    .MAX_SLOTS(MAX_SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_slot(in_slot),
    .in_x_pos(in_x_pos),
    .in_y_pos(in_y_pos),
    .in_pressure(in_pressure),
    .in_contact_kind(in_contact_kind),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_slot(out_slot),
    .out_x(out_x),
    .out_y(out_y),
    .out_pressure(out_pressure),
    .out_report_status(out_report_status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    if (rst_n && in_valid && in_ready) begin
      sb.note_report('{in_action, in_slot, in_x_pos, in_y_pos, in_pressure,
                       in_contact_kind, in_now_ms});
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{out_slot, out_x, out_y, out_pressure, out_report_status});
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [POS_W-1:0] clamp_pos(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return POS_W'(v);
  endfunction

  task automatic offer(logic action, logic [SLOT_W-1:0] slot, logic [POS_W-1:0] x,
                       logic [POS_W-1:0] y, logic [PRES_W-1:0] pressure,
                       logic [KIND_W-1:0] kind, logic [TIME_W-1:0] now);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_slot <= slot;
    in_x_pos <= x;
    in_y_pos <= y;
    in_pressure <= pressure;
    in_contact_kind <= kind;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
    if (action || (slot < MAX_SLOTS && (x != 0 || y != 0))) phase_items++;
  endtask

  task automatic touch_contact(int unsigned slot, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                               logic [KIND_W-1:0] kind, int unsigned advance);
    clock_ms += advance;
    offer(1'b0, SLOT_W'(slot), x, y, PRES_W'($urandom_range(0, 255)), kind, clock_ms);
  endtask

  task automatic release_frame(int unsigned advance);
    clock_ms += advance;
    offer(1'b1, SLOT_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 4095)),
          POS_W'($urandom_range(0, 4095)), PRES_W'($urandom_range(0, 255)),
          KIND_W'($urandom_range(0, 3)), clock_ms);
  endtask

  task automatic stray_report();
    int unsigned      slot;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 200);
    slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    if ($urandom_range(0, 15) == 0) begin
      x = '0;
      y = '0;
    end else begin
      x = POS_W'($urandom_range(0, 4095));
      y = POS_W'($urandom_range(0, 4095));
    end
    offer(($urandom_range(0, 9) == 0), SLOT_W'(slot), x, y, PRES_W'($urandom_range(0, 255)),
          KIND_W'($urandom_range(0, 3)), clock_ms);
  endtask

  // finger use, suppressed glove contacts, anchoring, travel, then glove reports
  task automatic glove_episode();
    int unsigned s;
    int          bx;
    int          by;
    int          radius;
    int          px;
    int          py;
    s = $urandom_range(0, FILTERED_SLOTS - 1);
    bx = $urandom_range(1, 4095);
    by = $urandom_range(0, 4095);
    touch_contact(s, POS_W'(bx), POS_W'(by), KIND_FINGER, $urandom_range(0, 40));
    if ($urandom_range(0, 1)) release_frame($urandom_range(0, 30));
    repeat ($urandom_range(0, 3)) begin
      touch_contact(s, POS_W'(bx), POS_W'(by), KIND_W'($urandom_range(1, 2)),
                    $urandom_range(0, cur_window + cur_window / 8 + 2));
    end
    touch_contact(s, POS_W'(bx), POS_W'(by), KIND_W'($urandom_range(1, 2)),
                  $urandom_range(cur_window + 1, cur_window + 3000));
    touch_contact(s, POS_W'(bx), POS_W'(by), KIND_W'($urandom_range(1, 2)),
                  $urandom_range(0, 20));
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) == 0) stray_report();
      radius = $urandom_range(0, cur_threshold + cur_threshold / 2 + 2);
      px = $urandom_range(0, 1) ? bx + radius : bx - radius;
      py = by + int'($urandom_range(0, radius / 2)) - radius / 4;
      touch_contact(s, clamp_pos(px), clamp_pos(py), KIND_W'($urandom_range(1, 2)),
                    $urandom_range(0, 20));
    end
    repeat ($urandom_range(1, 3)) begin
      px = bx + int'($urandom_range(0, 100)) - 50;
      py = by + int'($urandom_range(0, 100)) - 50;
      touch_contact(s, clamp_pos(px), clamp_pos(py), KIND_W'($urandom_range(1, 2)),
                    $urandom_range(0, 20));
    end
  endtask

  task automatic directed_checks();
    offer(1'b0, 4'd0, 12'd100, 12'd200, 8'd17, 2'd1, 32'd1000);
    offer(1'b0, 4'd0, 12'd0, 12'd0, 8'd255, KIND_FINGER, 32'd1001);
    offer(1'b0, 4'd12, 12'd300, 12'd300, 8'd40, 2'd1, 32'd1002);
    offer(1'b0, 4'd15, 12'd4095, 12'd4095, 8'd255, KIND_UNKNOWN, 32'hFFFF_FFFF);
    offer(1'b0, 4'd9, 12'd4095, 12'd4095, 8'd255, 2'd2, 32'd1003);
    offer(1'b0, 4'd4, 12'd1, 12'd0, 8'd0, 2'd1, 32'd1004);
    offer(1'b0, 4'd1, 12'd2048, 12'd1024, 8'd128, KIND_UNKNOWN, 32'd1005);
    offer(1'b0, 4'd1, 12'd2048, 12'd1024, 8'd90, KIND_FINGER, 32'd1010);
    offer(1'b1, 4'd0, 12'd0, 12'd0, 8'd0, KIND_FINGER, 32'd1020);
    offer(1'b0, 4'd2, 12'd700, 12'd700, 8'd33, 2'd1, 32'd1120);
    offer(1'b0, 4'd3, 12'd700, 12'd700, 8'd33, 2'd2, 32'd1000);
    offer(1'b0, 4'd3, 12'd500, 12'd500, 8'd60, 2'd2, 32'd1130);
    offer(1'b0, 4'd3, 12'd510, 12'd510, 8'd61, 2'd2, 32'd1131);
    offer(1'b0, 4'd3, 12'd530, 12'd500, 8'd62, 2'd2, 32'd1132);
    offer(1'b0, 4'd3, 12'd540, 12'd500, 8'd63, 2'd2, 32'd1133);
    offer(1'b0, 4'd0, 12'd800, 12'd900, 8'd70, KIND_FINGER, 32'd2000);
    offer(1'b1, 4'd15, 12'd4095, 12'd4095, 8'd255, KIND_UNKNOWN, 32'hFFFF_FFF0);
    offer(1'b0, 4'd0, 12'd800, 12'd900, 8'd71, 2'd1, 32'h0000_0010);
    offer(1'b0, 4'd0, 12'd800, 12'd900, 8'd72, 2'd1, 32'h0000_0010);
    offer(1'b0, 4'd0, 12'd0, 12'd4095, 8'd73, 2'd1, 32'h0000_0011);
    offer(1'b1, 4'd0, 12'd0, 12'd0, 8'd0, KIND_FINGER, 32'h0000_0012);
    offer(1'b0, 4'd0, 12'd4095, 12'd0, 8'd74, 2'd2, 32'h0000_0013);
    offer(1'b0, 4'd0, 12'd4095, 12'd0, 8'd75, 2'd2, 32'h0000_0014);
    offer(1'b0, 4'd0, 12'd4095, 12'd4095, 8'd76, 2'd2, 32'h0000_0015);
    offer(1'b0, 4'd0, 12'd1, 12'd1, 8'd77, 2'd2, 32'h0000_0016);
  endtask

  task automatic program_registers(logic [WIN_W-1:0] window, logic [THR_W-1:0] threshold);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FINGER_WINDOW;
    cfg_data <= CFG_DATA_W'(window);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_MOVE_THRESHOLD;
    cfg_data <= CFG_DATA_W'(threshold);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_window = window;
    cur_threshold = threshold;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    bit drain_done;
    bit hold_done;
    drain_done = 1'b0;
    hold_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) wait_for_results();
      case (phase / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: program_registers(16'd100, 12'd30);
        1: program_registers(16'd0, 12'd0);
        2: program_registers(16'd65535, 12'd4095);
        3: program_registers(16'd20, 12'd5);
        4: program_registers(WIN_W'($urandom_range(1, 400)), THR_W'($urandom_range(1, 200)));
        default: program_registers(16'd250, 12'd60);
      endcase
      if (phase == 0) directed_checks();
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (phase == 2 && !drain_done && phase_items >= 90) begin
          drain_done = 1'b1;
          wait_for_results();
        end
        if (phase == 4 && !hold_done && phase_items >= 60) begin
          hold_done = 1'b1;
          hold_request = 1'b1;
        end
        if ($urandom_range(0, 99) < 60) glove_episode();
        else stray_report();
      end
    end
    wait_for_results();
    if (sb.outstanding() != 0) $error("%0d results never arrived", sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
